>>> rtl/axis_collision_top_ten_tracker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the axis collision tracker
// Concurrent property wrappers with a common clock and reset.
// ----------------------------------------------------------------------------
`ifndef AXIS_COLLISION_TOP_TEN_TRACKER_ASSERT_SVH
`define AXIS_COLLISION_TOP_TEN_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define ACTT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("actt: same-cycle property failed");

// Next-cycle implication.
`define ACTT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("actt: next-cycle property failed");

`endif

>>> rtl/actt_pkg.sv
// ----------------------------------------------------------------------------
// actt_pkg
// Types and fixed constants of the axis collision tracker.
// ----------------------------------------------------------------------------
package actt_pkg;

  localparam int NUM_AXES = 3;
  localparam int AXIS_W   = 2;
  localparam int THRESH_W = 15;
  localparam int COUNT_W  = 32;
  localparam int SIZE_W   = 4;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd2048;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 32'hFFFF_FFFF;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_OUT
  } state_t;

endpackage

>>> rtl/actt_entry_ram.sv
// ----------------------------------------------------------------------------
// actt_entry_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module actt_entry_ram #(
  parameter int DEPTH = 30,
  parameter int WIDTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/axis_collision_top_ten_tracker.sv
// ----------------------------------------------------------------------------
// axis_collision_top_ten_tracker
// Per-axis collision counter and sorted list of the largest distinct samples.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Contents
//  s_axis    in         s_axis_tvalid/tready      tuser: axis; tdata: sample
//  m_axis    out        m_axis_tvalid/tready      tdata: result fields
//  cfg       in         cfg_we (no wait)          collision threshold
//
//  Steps: accept a transaction, walk the n entries of its axis list, move
//  the m entries beside the insertion point (m < LIST_DEPTH) if the list
//  changes, load the output. A new transaction is accepted only in ST_IDLE,
//  after the last one has passed its result to the output register.
//  Entries are read one at a time through the single read port of the entry RAM.
//  Reset is synchronous; entries need no clearing since only the first
//  list_size entries of an axis are ever read.
//  A result waiting on m_axis does not block a new input transaction; the
//  next result waits in ST_OUT until the output register is free.
//
module axis_collision_top_ten_tracker #(
  parameter int LIST_DEPTH   = 10,
  parameter int SAMPLE_WIDTH = 16,
  localparam int IN_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int RES_W = 38 + 2 * SAMPLE_WIDTH,
  localparam int OUT_W = ((RES_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [actt_pkg::THRESH_W-1:0] cfg_wdata,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_W-1:0]               s_axis_tdata,  // accel_sample, zero pad
  input  logic [actt_pkg::AXIS_W-1:0]   s_axis_tuser,  // axis
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // collided, collision_count, list_changed, list_size, list_largest,
  // list_smallest, zero pad
  output logic [OUT_W-1:0]              m_axis_tdata
);

  import actt_pkg::*;

  localparam int W        = SAMPLE_WIDTH;
  localparam int D        = LIST_DEPTH;
  localparam int IDX_W    = $clog2(D + 1);
  localparam int MEM_D    = NUM_AXES * D;
  localparam int ADDR_W   = $clog2(MEM_D);
  localparam int CMP_W    = (W > THRESH_W) ? W : THRESH_W;

  // --------------------------------------------------------------------------
  // Architectural state held in flops: threshold, counters and list sizes.
  // --------------------------------------------------------------------------
  logic [THRESH_W-1:0] threshold;
  logic [COUNT_W-1:0]  counters [NUM_AXES];
  logic [SIZE_W-1:0]   sizes    [NUM_AXES];

  state_t state, state_next;

  // Item context captured on acceptance.
  logic [AXIS_W-1:0]   ax_r;
  logic signed [W-1:0] sample_r;
  logic [ADDR_W-1:0]   base_r;
  logic [IDX_W-1:0]    n_cur;

  // Scan walk: read pointer, read-data tag and gathered facts.
  logic [IDX_W-1:0]    rd_i;
  logic                rd_v;
  logic [IDX_W-1:0]    rd_tag;
  logic                dup;
  logic [IDX_W-1:0]    lt_cnt;
  logic signed [W-1:0] e0, e1, elast;

  // Shift walk.
  logic                sh_up;
  logic [IDX_W-1:0]    sh_rd;
  logic [IDX_W-1:0]    sh_left;
  logic [IDX_W-1:0]    place_idx;
  logic                pend;
  logic [ADDR_W-1:0]   pend_addr;

  // Result held until the output register is free.
  logic                res_collided;
  logic [COUNT_W-1:0]  res_count;
  logic                res_changed;
  logic [SIZE_W-1:0]   res_size;
  logic signed [W-1:0] res_largest, res_smallest;

  // Output register.
  logic                m_valid;
  logic                m_collided;
  logic [COUNT_W-1:0]  m_count;
  logic                m_changed;
  logic [SIZE_W-1:0]   m_size;
  logic [W-1:0]        m_largest, m_smallest;

  // RAM ports.
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic signed [W-1:0] ram_wdata, ram_q;

  // --------------------------------------------------------------------------
  // Input decode: magnitude compare and per-axis lookups.
  // --------------------------------------------------------------------------
  logic signed [W-1:0] in_sample;
  logic [W-1:0]        in_mag;
  logic                in_hit;
  logic                in_axis_ok;
  logic [COUNT_W-1:0]  cnt_cur, cnt_new;
  logic [SIZE_W-1:0]   size_in;
  logic [ADDR_W-1:0]   base_in;
  logic                in_acc;

  assign in_sample  = s_axis_tdata[W-1:0];
  // Full-scale negative yields 2^(W-1), which fits in W unsigned bits.
  assign in_mag     = in_sample[W-1] ? (~in_sample + W'(1)) : in_sample;
  assign in_hit     = CMP_W'(in_mag) > CMP_W'(threshold);
  assign in_axis_ok = (s_axis_tuser == AXIS_X) || (s_axis_tuser == AXIS_Y) ||
                      (s_axis_tuser == AXIS_Z);
  assign cnt_cur    = in_axis_ok ? counters[s_axis_tuser] : '0;
  assign cnt_new    = (in_hit && (cnt_cur != COUNT_MAX)) ? cnt_cur + COUNT_W'(1)
                                                         : cnt_cur;
  assign size_in    = in_axis_ok ? sizes[s_axis_tuser] : '0;
  assign base_in    = ADDR_W'(s_axis_tuser) * ADDR_W'(D);

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Decision at the end of the scan.
  // --------------------------------------------------------------------------
  logic                scan_done, shift_done, out_load;
  logic                scan_rd, shift_rd;
  logic                full, unchanged;
  logic [IDX_W-1:0]    n_new;
  logic signed [W-1:0] dec_largest, dec_smallest;

  assign full      = (n_cur == IDX_W'(D));
  // A value below every entry of a full list is dropped; so is a duplicate.
  assign unchanged = dup || (full && (lt_cnt == '0));
  assign n_new     = (unchanged || full) ? n_cur : n_cur + IDX_W'(1);

  always_comb begin
    if (unchanged) begin
      dec_largest  = (n_cur != '0) ? elast : '0;
      dec_smallest = (n_cur != '0) ? e0 : '0;
    end else if (full) begin
      dec_largest  = (lt_cnt == IDX_W'(D)) ? sample_r : elast;
      dec_smallest = (lt_cnt == IDX_W'(1)) ? sample_r : e1;
    end else begin
      dec_largest  = (lt_cnt == n_cur) ? sample_r : elast;
      dec_smallest = (lt_cnt == '0) ? sample_r : e0;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state and RAM control.
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    scan_done  = 1'b0;
    shift_done = 1'b0;
    out_load   = 1'b0;
    scan_rd    = 1'b0;
    shift_rd   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = in_axis_ok ? ST_SCAN : ST_OUT;
        end
      end
      ST_SCAN: begin
        scan_rd = (rd_i < n_cur);
        if ((rd_i == n_cur) && !rd_v) begin
          scan_done  = 1'b1;
          state_next = unchanged ? ST_OUT : ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        shift_rd = (sh_left != '0);
        if ((sh_left == '0) && !pend) begin
          shift_done = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign ram_re    = scan_rd || shift_rd;
  assign ram_raddr = base_r + ADDR_W'(scan_rd ? rd_i : sh_rd);
  // Moved entries go out first; the new value lands once the walk is drained.
  assign ram_we    = pend || shift_done;
  assign ram_waddr = pend ? pend_addr : base_r + ADDR_W'(place_idx);
  assign ram_wdata = pend ? ram_q : sample_r;

  actt_entry_ram #(
    .DEPTH (MEM_D),
    .WIDTH (W)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Control and architectural registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
      for (int a = 0; a < NUM_AXES; a++) begin
        counters[a] <= '0;
        sizes[a]    <= '0;
      end
      rd_v    <= 1'b0;
      pend    <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      // Count the collision on acceptance; no other item can see it earlier.
      if (in_acc && in_axis_ok) begin
        counters[s_axis_tuser] <= cnt_new;
      end
      if (scan_done) begin
        sizes[ax_r] <= SIZE_W'(n_new);
      end
      rd_v <= scan_rd;
      pend <= shift_rd;
      // A fresh load wins; otherwise drop the valid once taken.
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_valid && m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r         <= s_axis_tuser;
      sample_r     <= in_sample;
      base_r       <= base_in;
      n_cur        <= IDX_W'(size_in);
      rd_i         <= '0;
      dup          <= 1'b0;
      lt_cnt       <= '0;
      res_collided <= in_hit;
      // Unused axis code: every field but collided reads zero.
      res_count    <= in_axis_ok ? cnt_new : '0;
      res_changed  <= 1'b0;
      res_size     <= '0;
      res_largest  <= '0;
      res_smallest <= '0;
    end

    if (scan_rd) begin
      rd_i   <= rd_i + IDX_W'(1);
      rd_tag <= rd_i;
    end
    if (rd_v) begin
      if (ram_q == sample_r) begin
        dup <= 1'b1;
      end
      if (ram_q < sample_r) begin
        lt_cnt <= lt_cnt + IDX_W'(1);
      end
      if (rd_tag == '0) begin
        e0 <= ram_q;
      end
      if (rd_tag == IDX_W'(1)) begin
        e1 <= ram_q;
      end
      if (rd_tag == n_cur - IDX_W'(1)) begin
        elast <= ram_q;
      end
    end

    if (scan_done) begin
      res_changed  <= !unchanged;
      res_size     <= SIZE_W'(n_new);
      res_largest  <= dec_largest;
      res_smallest <= dec_smallest;
      sh_up        <= !full;
      if (!full) begin
        // Open a slot: move entries at or above the insertion point up by one.
        sh_rd     <= n_cur - IDX_W'(1);
        sh_left   <= n_cur - lt_cnt;
        place_idx <= lt_cnt;
      end else begin
        // Evict the smallest: move the entries below the new value down.
        sh_rd     <= IDX_W'(1);
        sh_left   <= lt_cnt - IDX_W'(1);
        place_idx <= lt_cnt - IDX_W'(1);
      end
    end

    if (shift_rd) begin
      sh_left   <= sh_left - IDX_W'(1);
      sh_rd     <= sh_up ? sh_rd - IDX_W'(1) : sh_rd + IDX_W'(1);
      pend_addr <= sh_up ? ram_raddr + ADDR_W'(1) : ram_raddr - ADDR_W'(1);
    end

    if (out_load) begin
      m_collided <= res_collided;
      m_count    <= res_count;
      m_changed  <= res_changed;
      m_size     <= res_size;
      m_largest  <= res_largest;
      m_smallest <= res_smallest;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = OUT_W'({m_smallest, m_largest, m_size, m_changed,
                                 m_count, m_collided});

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic sizes_ok;

  assign sizes_ok = (sizes[0] <= SIZE_W'(D)) && (sizes[1] <= SIZE_W'(D)) &&
                    (sizes[2] <= SIZE_W'(D));

`include "axis_collision_top_ten_tracker_assert.svh"

  `ACTT_ASSERT_NXT(a_accept_leaves_idle, clk, rst, in_acc, state != ST_IDLE)
  `ACTT_ASSERT_IMP(a_ram_write_in_shift, clk, rst, ram_we, state == ST_SHIFT)
  `ACTT_ASSERT_IMP(a_sizes_bounded, clk, rst, 1'b1, sizes_ok)

endmodule
